@@ design/tvsm_pkg.sv @@
// Shared types and constants for the two-voice sample mixer.
// No dependencies; used by two_voice_sample_mixer.
package tvsm_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_WAVE_WR     = 3'd1,
        OP_SAMPLE_WR   = 3'd2,
        OP_WAVE_NOTE   = 3'd3,
        OP_SAMPLE_NOTE = 3'd4
    } op_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 28;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MUTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MUTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_VOLUME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LOOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PHASE     = 3'd5;

    // Field and state widths
    localparam int OP_W      = 3;
    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int FREQ_W    = 21;
    localparam int VOL_W     = 4;
    localparam int FRAC_BITS = 12;
    localparam int PHASE_W   = 28;
    localparam int STEP_W    = 20;

    // step = (freq * 32) / 125 computed as (freq * STEP_MUL) >> STEP_SHIFT,
    // STEP_MUL = ceil(2^33 / 125); exact for every 21-bit frequency
    localparam int STEP_MUL_W = 27;
    localparam int STEP_PROD_W = FREQ_W + STEP_MUL_W;
    localparam int STEP_SHIFT = 28;
    localparam logic [STEP_MUL_W-1:0] STEP_MUL = 27'd68719477;

endpackage

@@ design/two_voice_sample_mixer.sv @@
// Two-voice mixer: looping wavetable voice plus one-shot/looping sample voice.
// A tick beat reaches mixed_sample through the stage-1, execute and output registers.
// Throughput: one item per cycle while the output is not stalled; each voice's phase
// is read and rewritten in the single execute stage, next to one read port per sample memory.
// Reset clears phases and steps and loads the config defaults; the memories
// are not cleared. Depends on tvsm_pkg; both depths must be powers of two.
module two_voice_sample_mixer #(
    parameter int WAVE_DEPTH   = 256,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [tvsm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tvsm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [tvsm_pkg::OP_W-1:0]              operation,
    input  logic [tvsm_pkg::ADDR_W-1:0]            mem_address,
    input  logic signed [tvsm_pkg::BYTE_W-1:0]     mem_byte,
    input  logic [tvsm_pkg::FREQ_W-1:0]            note_frequency,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tvsm_pkg::BYTE_W-1:0]     mixed_sample
);

    localparam int WIDX_W = $clog2(WAVE_DEPTH);
    localparam int SIDX_W = $clog2(SAMPLE_DEPTH);
    localparam int WPH_W  = WIDX_W + tvsm_pkg::FRAC_BITS;
    localparam int SEXT_W = (SIDX_W > tvsm_pkg::ADDR_W) ? SIDX_W : tvsm_pkg::ADDR_W;
    localparam int PH_W   = tvsm_pkg::PHASE_W;
    localparam int BW     = tvsm_pkg::BYTE_W;

    // ---------------- configuration ----------------
    logic                         wave_mute_reg;
    logic                         sample_mute_reg;
    logic [tvsm_pkg::VOL_W-1:0]   sample_volume_reg;
    logic                         sample_loop_reg;
    logic [PH_W-1:0]              start_phase_reg;
    logic [PH_W-1:0]              end_phase_reg;
    logic [PH_W-1:0]              loop_span_reg;
    logic                         wrap_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mute_reg     <= 1'b1;
            sample_mute_reg   <= 1'b1;
            sample_volume_reg <= '1;
            sample_loop_reg   <= 1'b0;
            start_phase_reg   <= '0;
            end_phase_reg     <= '1;
            loop_span_reg     <= '1;
            wrap_en_reg       <= 1'b0;
        end
        else
        begin
            // derived loop controls follow the registers in the next cycle
            loop_span_reg <= end_phase_reg - start_phase_reg;
            wrap_en_reg   <= sample_loop_reg && (end_phase_reg > start_phase_reg);
            if (cfg_write)
            begin
                case (cfg_index)
                    tvsm_pkg::CFG_WAVE_MUTE:     wave_mute_reg     <= cfg_data[0];
                    tvsm_pkg::CFG_SAMPLE_MUTE:   sample_mute_reg   <= cfg_data[0];
                    tvsm_pkg::CFG_SAMPLE_VOLUME:
                        sample_volume_reg <= cfg_data[tvsm_pkg::VOL_W-1:0];
                    tvsm_pkg::CFG_SAMPLE_LOOP:   sample_loop_reg   <= cfg_data[0];
                    tvsm_pkg::CFG_START_PHASE:   start_phase_reg   <= cfg_data[PH_W-1:0];
                    tvsm_pkg::CFG_END_PHASE:     end_phase_reg     <= cfg_data[PH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- flow control ----------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_take;
    logic s2_stall;
    logic e_fire;
    logic in_fire;

    assign out_take = !out_valid_reg || out_ready;
    assign s2_stall = s2_valid_reg && !out_take;
    assign e_fire   = s1_valid_reg && !s2_stall;
    assign in_ready = !s1_valid_reg || e_fire;
    assign in_fire  = in_valid && in_ready;

    // ---------------- stage 1: capture, note step multiply ----------------
    logic [tvsm_pkg::OP_W-1:0]   s1_op_reg;
    logic [tvsm_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [BW-1:0]               s1_byte_reg;
    logic [tvsm_pkg::STEP_W-1:0] s1_step_reg;
    logic [tvsm_pkg::STEP_PROD_W-1:0] step_prod;

    assign step_prod = tvsm_pkg::STEP_PROD_W'(note_frequency)
                     * tvsm_pkg::STEP_PROD_W'(tvsm_pkg::STEP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (e_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= operation;
            s1_addr_reg <= mem_address;
            s1_byte_reg <= mem_byte;
            s1_step_reg <= step_prod[tvsm_pkg::STEP_SHIFT +: tvsm_pkg::STEP_W];
        end
    end

    // ---------------- execute stage: voice state and memories ----------------
    logic [WPH_W-1:0]            wave_phase_reg,  wave_phase_next;
    logic [WPH_W-1:0]            wave_step_reg,   wave_step_next;
    logic [PH_W-1:0]             sample_phase_reg, sample_phase_next;
    logic [tvsm_pkg::STEP_W-1:0] sample_step_reg, sample_step_next;
    logic                        sample_stopped_reg, sample_stopped_next;

    logic            op_tick;
    logic            op_wave_wr;
    logic            op_sample_wr;
    logic            samp_run;
    logic            samp_kill;
    logic [PH_W:0]   samp_sum;
    logic [PH_W:0]   samp_wrapped;
    logic [SEXT_W-1:0] wr_addr_ext;
    logic [SEXT_W-1:0] rd_addr_ext;
    logic [SIDX_W-1:0] sample_wr_idx;
    logic [SIDX_W-1:0] sample_rd_idx;
    logic [WIDX_W-1:0] wave_wr_idx;
    logic [WIDX_W-1:0] wave_rd_idx;

    assign samp_sum     = {1'b0, sample_phase_reg} + (PH_W+1)'(sample_step_reg);
    assign samp_wrapped = samp_sum - {1'b0, loop_span_reg};
    assign samp_run     = !sample_mute_reg && !sample_stopped_reg;

    assign wr_addr_ext   = SEXT_W'(s1_addr_reg);
    assign rd_addr_ext   = SEXT_W'(sample_phase_reg[PH_W-1:tvsm_pkg::FRAC_BITS]);
    assign sample_wr_idx = wr_addr_ext[SIDX_W-1:0];
    assign sample_rd_idx = rd_addr_ext[SIDX_W-1:0];
    assign wave_wr_idx   = s1_addr_reg[WIDX_W-1:0];
    assign wave_rd_idx   = wave_phase_reg[WPH_W-1:tvsm_pkg::FRAC_BITS];

    always_comb
    begin
        wave_phase_next     = wave_phase_reg;
        wave_step_next      = wave_step_reg;
        sample_phase_next   = sample_phase_reg;
        sample_step_next    = sample_step_reg;
        sample_stopped_next = sample_stopped_reg;
        op_tick             = 1'b0;
        op_wave_wr          = 1'b0;
        op_sample_wr        = 1'b0;
        samp_kill           = 1'b0;
        case (tvsm_pkg::op_t'(s1_op_reg))
            tvsm_pkg::OP_TICK:
            begin
                op_tick = 1'b1;
                if (!wave_mute_reg)
                begin
                    wave_phase_next = wave_phase_reg + wave_step_reg;
                end
                if (samp_run)
                begin
                    if (samp_sum >= {1'b0, end_phase_reg})
                    begin
                        if (wrap_en_reg)
                        begin
                            sample_phase_next = samp_wrapped[PH_W-1:0];
                        end
                        else
                        begin
                            // one-shot finished: silence this beat and park at start
                            samp_kill           = 1'b1;
                            sample_stopped_next = 1'b1;
                            sample_phase_next   = start_phase_reg;
                        end
                    end
                    else
                    begin
                        sample_phase_next = samp_sum[PH_W-1:0];
                    end
                end
            end
            tvsm_pkg::OP_WAVE_WR:   op_wave_wr = 1'b1;
            tvsm_pkg::OP_SAMPLE_WR: op_sample_wr = 1'b1;
            tvsm_pkg::OP_WAVE_NOTE:
            begin
                wave_phase_next = '0;
                wave_step_next  = WPH_W'(s1_step_reg);
            end
            tvsm_pkg::OP_SAMPLE_NOTE:
            begin
                sample_step_next    = s1_step_reg;
                sample_phase_next   = start_phase_reg;
                sample_stopped_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_phase_reg     <= '0;
            wave_step_reg      <= '0;
            sample_phase_reg   <= '0;
            sample_step_reg    <= '0;
            sample_stopped_reg <= 1'b1;
        end
        else if (e_fire)
        begin
            wave_phase_reg     <= wave_phase_next;
            wave_step_reg      <= wave_step_next;
            sample_phase_reg   <= sample_phase_next;
            sample_step_reg    <= sample_step_next;
            sample_stopped_reg <= sample_stopped_next;
        end
    end

    // Memories: one access per beat, write or read, at the execute stage
    logic [BW-1:0]        wave_mem [WAVE_DEPTH];
    logic [BW-1:0]        sample_mem [SAMPLE_DEPTH];
    logic signed [BW-1:0] wave_rd_reg;
    logic signed [BW-1:0] sample_rd_reg;

    always_ff @(posedge clk)
    begin
        if (e_fire && op_wave_wr)
        begin
            wave_mem[wave_wr_idx] <= s1_byte_reg;
        end
        if (e_fire && op_tick)
        begin
            wave_rd_reg <= wave_mem[wave_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire && op_sample_wr)
        begin
            sample_mem[sample_wr_idx] <= s1_byte_reg;
        end
        if (e_fire && op_tick)
        begin
            sample_rd_reg <= sample_mem[sample_rd_idx];
        end
    end

    // ---------------- stage 2: mix ----------------
    logic                       s2_wave_on_reg;
    logic                       s2_samp_on_reg;
    logic [tvsm_pkg::VOL_W-1:0] s2_vol_reg;
    logic signed [12:0]         s2_prod;
    logic signed [8:0]          s2_b;
    logic signed [BW-1:0]       s2_a;
    logic signed [9:0]          s2_sum;
    logic signed [BW-1:0]       mixed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_stall)
        begin
            s2_valid_reg <= e_fire && op_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire && op_tick)
        begin
            s2_wave_on_reg <= !wave_mute_reg;
            s2_samp_on_reg <= samp_run && !samp_kill;
            s2_vol_reg     <= sample_volume_reg;
        end
    end

    assign s2_prod = $signed(sample_rd_reg) * $signed({1'b0, s2_vol_reg});
    assign s2_b    = s2_samp_on_reg ? s2_prod[12:4] : 9'sd0;
    assign s2_a    = s2_wave_on_reg ? wave_rd_reg : 8'sd0;
    assign s2_sum  = {{2{s2_a[BW-1]}}, s2_a} + {s2_b[8], s2_b};

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && s2_valid_reg)
        begin
            mixed_reg <= s2_sum[8:1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;

`ifndef SYNTH
    // a held item in stage 1 must block new input beats
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !e_fire) |-> !in_ready)
        else $error("input accepted over a stalled execute stage");

    // voice state only moves when an item executes
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !e_fire |=> ($stable(wave_phase_reg) && $stable(sample_phase_reg)))
        else $error("voice phase changed without an executed item");

    // a stalled mix stage keeps its beat
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_stall |=> (s2_valid_reg && $stable(wave_rd_reg) && $stable(sample_rd_reg)))
        else $error("mix stage lost or changed a stalled beat");
`endif

endmodule
